// File: sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int IDX_W             = 10;
  localparam int DATA_W            = 32;
  localparam int TABLE_DEPTH_DEF   = 1024;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         last_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CMP,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // take a search item into the range registers
    logic load_wr;   // write one table entry
    logic probe;     // issue midpoint read
    logic advance;   // apply compare result
    logic publish;   // move result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_ok;
    logic hit;
    logic lower;     // probed entry below key
    logic mid_zero;
    logic out_free;
  } status_t;

endpackage

// File: sv/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted table of signed entries with load and binary search.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_stall  | op, first_index, last_index, value
//   out     | output    | out_valid/out_stall| found, position
//
// A load gives no result. A search passes through ST_CHECK (range check and
// midpoint read) and ST_CMP (compare) once per probe, then ST_FIN to
// publish the result; probes run one at a time through the single read
// port of the table memory.
// Reset clears control only; table contents are undefined until loaded.
// out_stall holds the result in the output register; the next item is taken
// meanwhile, and a second finished search waits until that register frees.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t status;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: sv/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for loads and searches: probe, compare, finish.
// ----------------------------------------------------------------------------
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_SEARCH) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = status.range_ok ? ST_CMP : ST_FIN;
      end
      ST_CMP: begin
        if (status.hit) begin
          state_nxt = ST_FIN;
        end else if (status.lower) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = status.mid_zero ? ST_FIN : ST_CHECK;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid && in_op == OP_SEARCH;
        cmd.load_wr = in_valid && in_op == OP_LOAD;
      end
      ST_CHECK: cmd.probe   = status.range_ok;
      ST_CMP:   cmd.advance = 1'b1;
      ST_FIN:   cmd.publish = status.out_free;
      default:  cmd         = '0;
    endcase
  end

endmodule

// File: sv/stbs_dp.sv
// ----------------------------------------------------------------------------
// stbs_dp
// Range registers, midpoint, table memory, compare and output register.
// ----------------------------------------------------------------------------
module stbs_dp
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // lo may step one past the top index, hence the extra bit
  logic [IDX_W:0]           lo_r;
  logic [IDX_W-1:0]         hi_r;
  logic [IDX_W-1:0]         mid_r;
  logic signed [DATA_W-1:0] key_r;
  logic                     found_r;
  logic [IDX_W-1:0]         pos_r;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r;

  logic [IDX_W:0]           sum;
  logic [IDX_W-1:0]         mid;
  logic [IDX_W-1:0]         hi_sat;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] entry;
  logic                     wr_en;

  assign sum   = lo_r + {1'b0, hi_r};
  assign mid   = sum[IDX_W:1];
  assign entry = $signed(rdata);

  assign hi_sat = (32'(in_data.last_index) > 32'(TABLE_DEPTH - 1))
                ? IDX_W'(TABLE_DEPTH - 1) : in_data.last_index;

  // drop loads beyond the table
  assign wr_en = cmd.load_wr && (32'(in_data.first_index) < 32'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_data.first_index)),
    .wdata (in_data.value),
    .raddr (AW'(mid)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lo_r    <= {1'b0, in_data.first_index};
      hi_r    <= hi_sat;
      key_r   <= in_data.value;
      found_r <= 1'b0;
      pos_r   <= '0;
    end
    if (cmd.probe) begin
      mid_r <= mid;
    end
    if (cmd.advance) begin
      if (entry == key_r) begin
        found_r <= 1'b1;
        pos_r   <= mid_r;
      end else if (entry < key_r) begin
        lo_r <= {1'b0, mid_r} + 1'b1;
      end else if (mid_r != '0) begin
        hi_r <= mid_r - 1'b1;
      end
    end
    if (cmd.publish) begin
      out_data_r.found    <= found_r;
      out_data_r.position <= pos_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.range_ok = lo_r <= {1'b0, hi_r};
  assign status.hit      = entry == key_r;
  assign status.lower    = entry < key_r;
  assign status.mid_zero = mid_r == '0;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sim/sorted_table_binary_search_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top_tb
// Self-checking bench for the sorted table search block. It loads table
// entries and issues searches over valid/stall channels with random idle
// cycles on both sides. Each search result is checked in order against a
// behavioral shadow-table search or a directed row's fixed expected result.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top_tb;
  import stbs_pkg::*;

  localparam int DEPTH          = TABLE_DEPTH_DEF;
  localparam int FILL_DEPTH     = 256;
  localparam int RANDOM_ITEMS   = 180;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fff_ffff;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  logic signed [DATA_W-1:0] shadow_mem [DEPTH];
  out_item_t                pending_results [$];
  stim_row_t                directed_rows [$];
  out_item_t                oldest_result;
  int                       mismatch_count = 0;
  int                       results_taken  = 0;
  int                       idle_run       = 0;
  bit                       steady_in      = 1'b0;
  bit                       hold_done      = 1'b0;

  sorted_table_binary_search_top #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic in_item_t make_item(logic op, int lo, int hi,
                                         logic [DATA_W-1:0] v);
    in_item_t it;
    it.op          = op;
    it.first_index = IDX_W'(lo);
    it.last_index  = IDX_W'(hi);
    it.value       = v;
    return it;
  endfunction

  // Walk the midpoint probes over the shadow table.
  function automatic out_item_t search_shadow(in_item_t it);
    out_item_t                r;
    int                       lo;
    int                       hi;
    int                       mid;
    logic signed [DATA_W-1:0] key;
    r   = '0;
    key = it.value;
    lo  = it.first_index;
    hi  = it.last_index;
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_mem[mid] == key) begin
        r.found    = 1'b1;
        r.position = IDX_W'(mid);
        break;
      end else if (shadow_mem[mid] < key) begin
        lo = mid + 1;
      end else begin
        if (mid == 0) break;
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  function automatic int idle_gap();
    int gap;
    gap = 0;
    while (!steady_in && $urandom_range(0, 99) < 35) gap++;
    return gap;
  endfunction

  task automatic add_row(logic op, int lo, int hi, logic signed [DATA_W-1:0] v,
                         logic typed, logic f, int p);
    stim_row_t r;
    r.item          = make_item(op, lo, hi, v);
    r.typed         = typed;
    r.want.found    = f;
    r.want.position = IDX_W'(p);
    directed_rows.push_back(r);
  endtask

  // Offer one item, hold it until the transfer, then record its effect.
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (it.op == OP_LOAD) begin
      if (it.first_index < DEPTH) shadow_mem[it.first_index] = it.value;
    end else if (typed) begin
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(search_shadow(it));
    end
  endtask

  // Receiver: random stalls, one long hold-off, one stretch without stalls.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_taken >= 40) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (results_taken >= 60 && results_taken < 100) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_taken++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual found=%0b position=%0d",
                 $time, out_data.found, out_data.position);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.found !== oldest_result.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, oldest_result.found, out_data.found);
          mismatch_count++;
        end
        if (out_data.position !== oldest_result.position) begin
          $display("%0t: position mismatch: expected %0d, actual %0d",
                   $time, oldest_result.position, out_data.position);
          mismatch_count++;
        end
      end
    end
  end

  // End the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
    else idle_run++;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_run);
      $display("sorted_table_binary_search_top regression: fail");
      $finish;
    end
  end

  initial begin
    in_item_t  it;
    out_item_t none;
    longint    acc;
    longint    lo_v;
    longint    hi_v;
    longint    rnd64;
    int        lo;
    int        hi;
    int        a;
    int        b;
    int        idx;
    int        sel;
    logic [DATA_W-1:0] key;

    none     = '0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Small sorted table in entries 0..6 plus the top entry.
    add_row(OP_LOAD,   0,    0,    VMIN + 1, 1'b0, 1'b0, 0);
    add_row(OP_LOAD,   1,    0,    -1000,    1'b0, 1'b0, 0);
    add_row(OP_LOAD,   2,    0,    -1000,    1'b0, 1'b0, 0);
    add_row(OP_LOAD,   3,    0,    0,        1'b0, 1'b0, 0);
    add_row(OP_LOAD,   4,    0,    77,       1'b0, 1'b0, 0);
    add_row(OP_LOAD,   5,    1023, 5000,     1'b0, 1'b0, 0);
    add_row(OP_LOAD,   6,    0,    VMAX,     1'b0, 1'b0, 0);
    add_row(OP_LOAD,   1023, 511,  VMIN,     1'b0, 1'b0, 0);
    add_row(OP_SEARCH, 0,    6,    VMAX,     1'b1, 1'b1, 6);
    add_row(OP_SEARCH, 1023, 1023, VMIN,     1'b1, 1'b1, 1023);
    // Key below entry 0: the search stops at midpoint zero.
    add_row(OP_SEARCH, 0,    6,    VMIN,     1'b1, 1'b0, 0);
    add_row(OP_SEARCH, 5,    2,    0,        1'b1, 1'b0, 0);
    add_row(OP_SEARCH, 1023, 0,    -1,       1'b1, 1'b0, 0);
    add_row(OP_SEARCH, 3,    3,    0,        1'b0, 1'b0, 0);
    add_row(OP_SEARCH, 0,    6,    -1000,    1'b0, 1'b0, 0);
    add_row(OP_SEARCH, 2,    6,    -1000,    1'b0, 1'b0, 0);
    add_row(OP_SEARCH, 0,    6,    78,       1'b0, 1'b0, 0);
    add_row(OP_SEARCH, 0,    6,    VMAX - 1, 1'b0, 1'b0, 0);
    add_row(OP_SEARCH, 0,    6,    VMIN + 1, 1'b0, 1'b0, 0);
    add_row(OP_SEARCH, 0,    6,    5000,     1'b0, 1'b0, 0);
    // Break the order, then search the unsorted range.
    add_row(OP_LOAD,   4,    0,    -9999,    1'b0, 1'b0, 0);
    add_row(OP_SEARCH, 0,    6,    -9999,    1'b0, 1'b0, 0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Fill the low part of the table in ascending order, with some duplicate
    // runs; searches below stay inside it.
    acc = VMIN;
    for (int i = 0; i < FILL_DEPTH; i++) begin
      if (i == FILL_DEPTH - 1) acc = VMAX;
      send_item(make_item(OP_LOAD, i, $urandom_range(0, DEPTH - 1), DATA_W'(acc)),
                1'b0, none);
      if ($urandom_range(0, 15) != 0) acc += $urandom_range(1, 4_000_000);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_in = (n >= 60 && n < 110);
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            lo = 0;
            hi = FILL_DEPTH - 1;
          end
          4, 5, 6: begin
            a  = $urandom_range(0, FILL_DEPTH - 1);
            b  = $urandom_range(0, FILL_DEPTH - 1);
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
          end
          7: begin
            lo = $urandom_range(0, FILL_DEPTH - 1);
            hi = $urandom_range(0, FILL_DEPTH - 1);
          end
          8: begin
            lo = $urandom_range(0, FILL_DEPTH - 1);
            hi = lo + $urandom_range(0, 3);
            if (hi > FILL_DEPTH - 1) hi = FILL_DEPTH - 1;
          end
          default: begin
            lo = $urandom_range(0, FILL_DEPTH - 1);
            hi = lo;
          end
        endcase
        idx = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, FILL_DEPTH - 1);
        case ($urandom_range(0, 3))
          0, 1:    key = shadow_mem[idx];
          2:       key = $urandom_range(0, 1) ? shadow_mem[idx] + 1 : shadow_mem[idx] - 1;
          default: key = $urandom;
        endcase
        it = make_item(OP_SEARCH, lo, hi, key);
      end else if (sel < 88) begin
        // Rewrite one entry with a value that keeps its neighbors in order.
        idx  = $urandom_range(1, FILL_DEPTH - 2);
        lo_v = shadow_mem[idx - 1];
        hi_v = shadow_mem[idx + 1];
        rnd64 = $urandom;
        if (lo_v <= hi_v) key = DATA_W'(lo_v + rnd64 % (hi_v - lo_v + 1));
        else key = $urandom;
        it = make_item(OP_LOAD, idx, $urandom_range(0, DEPTH - 1), key);
      end else begin
        it = make_item(OP_LOAD, $urandom_range(0, DEPTH - 1),
                       $urandom_range(0, DEPTH - 1), $urandom);
      end
      send_item(it, 1'b0, none);
    end
    steady_in = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sorted_table_binary_search_top regression: pass");
    end else begin
      $display("sorted_table_binary_search_top regression: fail");
    end
    $finish;
  end

endmodule
